// ===== design/cct_pkg.sv =====
// ----------------------------------------------------------------------------
// cct_pkg
// Shared types, command and register codes for the capture/compare timer.
// ----------------------------------------------------------------------------
`default_nettype none

package cct_pkg;

  localparam int MAX_CHANNELS = 6;
  localparam int CMD_W = 3;
  localparam int CHAN_W = 3;
  localparam int VALUE_W = 32;
  localparam int PRESCALE_W = 16;
  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W = 16;

  typedef enum logic [CMD_W-1:0] {
    CMD_TICK    = 3'd0,
    CMD_START   = 3'd1,
    CMD_STOP    = 3'd2,
    CMD_COUNT   = 3'd3,
    CMD_CLEAR   = 3'd4,
    CMD_CAPTURE = 3'd5,
    CMD_WRITE   = 3'd6,
    CMD_READ    = 3'd7
  } cmd_t;

  localparam logic [CFG_INDEX_W-1:0] REG_COUNT_MODE   = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_WIDTH_SELECT = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_PRESCALE     = 2'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_IRQ_ENABLE   = 2'd3;

  localparam logic [1:0] TIMER_MODE   = 2'd0;
  localparam logic [1:0] COUNTER_MODE = 2'd1;

  localparam logic [1:0] WIDTH_16 = 2'd0;
  localparam logic [1:0] WIDTH_8  = 2'd1;
  localparam logic [1:0] WIDTH_24 = 2'd2;
  localparam logic [1:0] WIDTH_32 = 2'd3;

  // counter side result handed to the channel store
  typedef struct packed {
    logic               tick_incr;
    logic [VALUE_W-1:0] count_next;
    logic               run_next;
  } ctr_status_t;

  function automatic logic [VALUE_W-1:0] width_mask(input logic [1:0] sel);
    logic [VALUE_W-1:0] m;
    case (sel)
      WIDTH_16: m = 32'h0000_FFFF;
      WIDTH_8:  m = 32'h0000_00FF;
      WIDTH_24: m = 32'h00FF_FFFF;
      WIDTH_32: m = 32'hFFFF_FFFF;
      default:  m = 32'hFFFF_FFFF;
    endcase
    return m;
  endfunction

endpackage

`default_nettype wire

// ===== design/cct_counter.sv =====
// ----------------------------------------------------------------------------
// cct_counter
// Tick divider, 32-bit counter and run flag; updated once per processed item.
// ----------------------------------------------------------------------------
`default_nettype none

module cct_counter (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                fire,
  input  wire cct_pkg::cmd_t                       cmd,
  input  wire logic [1:0]                          count_mode,
  input  wire logic [cct_pkg::PRESCALE_W-1:0]      prescale_limit,
  output logic [cct_pkg::VALUE_W-1:0]              count_value,
  output cct_pkg::ctr_status_t                     status
);

  logic [cct_pkg::PRESCALE_W-1:0] prescale_count;
  logic [cct_pkg::PRESCALE_W-1:0] prescale_count_next;
  logic [cct_pkg::PRESCALE_W:0]   div_inc;
  logic                           run_flag;

  always_comb begin
    div_inc = {1'b0, prescale_count} + {{cct_pkg::PRESCALE_W{1'b0}}, 1'b1};
    prescale_count_next = prescale_count;
    status.tick_incr = 1'b0;
    status.count_next = count_value;
    status.run_next = run_flag;
    case (cmd)
      cct_pkg::CMD_TICK: begin
        if (run_flag) begin
          if (div_inc < {1'b0, prescale_limit}) begin
            prescale_count_next = div_inc[cct_pkg::PRESCALE_W-1:0];
          end else begin
            prescale_count_next = '0;
            status.tick_incr = 1'b1;
            status.count_next = count_value + 32'd1;
          end
        end
      end
      cct_pkg::CMD_START: begin
        if (count_mode == cct_pkg::TIMER_MODE) begin
          status.run_next = 1'b1;
        end
      end
      cct_pkg::CMD_STOP: begin
        status.run_next = 1'b0;
      end
      cct_pkg::CMD_COUNT: begin
        if (count_mode == cct_pkg::COUNTER_MODE) begin
          status.count_next = count_value + 32'd1;
        end
      end
      cct_pkg::CMD_CLEAR: begin
        status.count_next = '0;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count_value <= '0;
      prescale_count <= '0;
      run_flag <= 1'b0;
    end else if (fire) begin
      count_value <= status.count_next;
      prescale_count <= prescale_count_next;
      run_flag <= status.run_next;
    end
  end

endmodule

`default_nettype wire

// ===== design/cct_channels.sv =====
// ----------------------------------------------------------------------------
// cct_channels
// Compare value store, per-channel masked compare and compare read.
// ----------------------------------------------------------------------------
`default_nettype none

module cct_channels #(
  parameter int CHANNELS = 6
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                fire,
  input  wire cct_pkg::cmd_t                       cmd,
  input  wire logic [cct_pkg::CHAN_W-1:0]          channel,
  input  wire logic [cct_pkg::VALUE_W-1:0]         write_value,
  input  wire logic [cct_pkg::VALUE_W-1:0]         count_value,
  input  wire cct_pkg::ctr_status_t                status,
  input  wire logic [1:0]                          width_select,
  input  wire logic [cct_pkg::MAX_CHANNELS-1:0]    irq_enable,
  output logic [cct_pkg::MAX_CHANNELS-1:0]         hits,
  output logic [cct_pkg::MAX_CHANNELS-1:0]         irq,
  output logic [cct_pkg::VALUE_W-1:0]              rval
);

  localparam int IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  logic [cct_pkg::VALUE_W-1:0] compare_values [CHANNELS];
  logic [cct_pkg::VALUE_W-1:0] mask;
  logic [cct_pkg::VALUE_W-1:0] masked_count;
  logic                        ch_ok;
  logic [IDX_W-1:0]            idx;

  assign ch_ok = ({{(32-cct_pkg::CHAN_W){1'b0}}, channel} < 32'(CHANNELS));
  assign idx = channel[IDX_W-1:0];
  assign mask = cct_pkg::width_mask(width_select);
  assign masked_count = status.count_next & mask;

  always_comb begin
    hits = '0;
    for (int i = 0; i < CHANNELS; i++) begin
      hits[i] = status.tick_incr && ((compare_values[i] & mask) == masked_count);
    end
    irq = hits & irq_enable;
    rval = '0;
    if (cmd == cct_pkg::CMD_READ && ch_ok) begin
      rval = compare_values[idx];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < CHANNELS; i++) begin
        compare_values[i] <= '0;
      end
    end else if (fire && ch_ok) begin
      if (cmd == cct_pkg::CMD_CAPTURE) begin
        compare_values[idx] <= count_value;
      end else if (cmd == cct_pkg::CMD_WRITE) begin
        compare_values[idx] <= write_value;
      end
    end
  end

endmodule

`default_nettype wire

// ===== design/capture_compare_timer_top.sv =====
// ----------------------------------------------------------------------------
// capture_compare_timer_top
// Timer/counter with tick divider and capture/compare channels.
// ----------------------------------------------------------------------------
// usage:
//   input channel (in_valid/in_ready) carries one command item: tick, start,
//   stop, count, clear, capture, write compare or read compare
//   output channel (out_valid/out_ready) returns exactly one result item per
//   input item, in order: compare hits, irq hits, read value, run state
//   configuration writes go through cfg_we/cfg_index/cfg_data with no wait;
//   the user must make them only while no item is in flight; not enforced
//   an accepted item goes into the input register, then its result into the
//   result register; throughput one item per cycle while the receiver does
//   not stall, set by the single compare/increment pass between the registers
//   when the receiver stalls, the result register holds and the input
//   register fills; in_ready drops only when both are full
//   reset (rst, synchronous) clears counter, divider, run flag, compare
//   values and configuration to zero and empties both registers
// ----------------------------------------------------------------------------
`default_nettype none

module capture_compare_timer_top #(
  parameter int CHANNELS = 6
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                in_valid,
  output logic                                     in_ready,
  input  wire logic [cct_pkg::CMD_W-1:0]           cmd,
  input  wire logic [cct_pkg::CHAN_W-1:0]          channel,
  input  wire logic [cct_pkg::VALUE_W-1:0]         write_value,
  output logic                                     out_valid,
  input  wire logic                                out_ready,
  output logic [cct_pkg::MAX_CHANNELS-1:0]         compare_hits,
  output logic [cct_pkg::MAX_CHANNELS-1:0]         irq_hits,
  output logic [cct_pkg::VALUE_W-1:0]              read_value,
  output logic                                     is_running,
  input  wire logic                                cfg_we,
  input  wire logic [cct_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  wire logic [cct_pkg::CFG_DATA_W-1:0]      cfg_data
);

  logic [1:0]                          count_mode;
  logic [1:0]                          width_select;
  logic [cct_pkg::PRESCALE_W-1:0]      prescale_limit;
  logic [cct_pkg::MAX_CHANNELS-1:0]    compare_irq_enable;

  logic                                s1_valid;
  cct_pkg::cmd_t                       s1_cmd;
  logic [cct_pkg::CHAN_W-1:0]          s1_channel;
  logic [cct_pkg::VALUE_W-1:0]         s1_write_value;
  logic                                adv;

  logic [cct_pkg::VALUE_W-1:0]         count_value;
  cct_pkg::ctr_status_t                status;
  logic [cct_pkg::MAX_CHANNELS-1:0]    hits;
  logic [cct_pkg::MAX_CHANNELS-1:0]    irq;
  logic [cct_pkg::VALUE_W-1:0]         rval;

  assign adv = s1_valid && (!out_valid || out_ready);
  assign in_ready = !s1_valid || adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      count_mode <= '0;
      width_select <= '0;
      prescale_limit <= '0;
      compare_irq_enable <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        cct_pkg::REG_COUNT_MODE:   count_mode <= cfg_data[1:0];
        cct_pkg::REG_WIDTH_SELECT: width_select <= cfg_data[1:0];
        cct_pkg::REG_PRESCALE:     prescale_limit <= cfg_data;
        cct_pkg::REG_IRQ_ENABLE:   compare_irq_enable <= cfg_data[cct_pkg::MAX_CHANNELS-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s1_cmd <= cct_pkg::cmd_t'(cmd);
      s1_channel <= channel;
      s1_write_value <= write_value;
    end
  end

  cct_counter u_counter (
    .clk            (clk),
    .rst            (rst),
    .fire           (adv),
    .cmd            (s1_cmd),
    .count_mode     (count_mode),
    .prescale_limit (prescale_limit),
    .count_value    (count_value),
    .status         (status)
  );

  cct_channels #(
    .CHANNELS (CHANNELS)
  ) u_channels (
    .clk          (clk),
    .rst          (rst),
    .fire         (adv),
    .cmd          (s1_cmd),
    .channel      (s1_channel),
    .write_value  (s1_write_value),
    .count_value  (count_value),
    .status       (status),
    .width_select (width_select),
    .irq_enable   (compare_irq_enable),
    .hits         (hits),
    .irq          (irq),
    .rval         (rval)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      compare_hits <= hits;
      irq_hits <= irq;
      read_value <= rval;
      is_running <= status.run_next;
    end
  end

  a_irq_subset: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ((irq_hits & ~compare_hits) == '0))
    else $error("irq hits outside compare hits");

  a_hits_need_run: assert property (@(posedge clk) disable iff (rst)
    (out_valid && compare_hits != '0) |-> is_running)
    else $error("compare hit while stopped");

  a_full_blocks_input: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && out_valid && !out_ready) |-> !in_ready)
    else $error("input taken while both registers full");

  a_stage_holds: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && !adv) |=> (s1_valid && $stable(s1_cmd) && $stable(s1_write_value)))
    else $error("stalled input register lost its item");

endmodule

`default_nettype wire
